@@ src/opc_pkg.sv @@
// ----------------------------------------------------------------------------
// opc_pkg
// Shared types and constants for the order-preserving compaction block.
// ----------------------------------------------------------------------------
package opc_pkg;

   localparam int DEF_MAX_ELEMENTS = 32;
   localparam int VALUE_W          = 32;
   localparam int COUNT_W          = 6;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               is_real;
      logic               last_element;
   } opc_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] out_value;
      logic               out_real;
      logic [COUNT_W-1:0] real_count;
      logic               last_result;
   } opc_rsp_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SHIFT,
      ST_EMIT
   } opc_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // store the accepted element
      logic level;   // run one shifter level
      logic emit;    // result transfer done, advance to next slot
   } opc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic vec_end;      // element at the input closes the vector
      logic more_levels;  // another shifter level is needed
      logic emit_last;    // slot at the output is the final one
   } opc_stat_type;

endpackage

@@ src/opc_ctrl.sv @@
// ----------------------------------------------------------------------------
// opc_ctrl
// Sequencer: load elements, run shifter levels, emit results.
// ----------------------------------------------------------------------------
module opc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  opc_pkg::opc_stat_type stat,
   output opc_pkg::opc_cmd_type  cmd
);

   opc_pkg::opc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= opc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         opc_pkg::ST_LOAD: begin
            if (req_valid && stat.vec_end) begin
               state_in = opc_pkg::ST_SHIFT;
            end
         end
         opc_pkg::ST_SHIFT: begin
            if (!stat.more_levels) begin
               state_in = opc_pkg::ST_EMIT;
            end
         end
         opc_pkg::ST_EMIT: begin
            if (!rsp_stall && stat.emit_last) begin
               state_in = opc_pkg::ST_LOAD;
            end
         end
         default: state_in = opc_pkg::ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         opc_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         opc_pkg::ST_SHIFT: begin
            cmd.level = stat.more_levels;
         end
         opc_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit  = !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

@@ src/opc_datapath.sv @@
// ----------------------------------------------------------------------------
// opc_datapath
// Slot registers, dummy prefix count and the log-step shifter network.
// ----------------------------------------------------------------------------
module opc_datapath #(
   parameter int MAX_ELEMENTS = opc_pkg::DEF_MAX_ELEMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  opc_pkg::opc_req_type  req_data,
   output opc_pkg::opc_rsp_type  rsp_data,
   input  opc_pkg::opc_cmd_type  cmd,
   output opc_pkg::opc_stat_type stat
);

   localparam int CW     = $clog2(MAX_ELEMENTS + 1);  // counts 0..MAX
   localparam int IW     = $clog2(MAX_ELEMENTS);      // slot index
   localparam int LEVELS = $clog2(MAX_ELEMENTS);      // most levels needed
   localparam int LW     = $clog2(LEVELS + 1);
   localparam int JW     = CW + 1;                    // jump distance

   logic [opc_pkg::VALUE_W-1:0] val_ff  [MAX_ELEMENTS];
   logic [CW-1:0]               step_ff [MAX_ELEMENTS];
   logic [opc_pkg::VALUE_W-1:0] val_in  [MAX_ELEMENTS];
   logic [CW-1:0]               step_in [MAX_ELEMENTS];

   logic [IW-1:0] load_idx_ff;
   logic [CW-1:0] dummy_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] nreal_ff;
   logic [LW-1:0] lvl_ff;
   logic [IW-1:0] emit_idx_ff;

   logic [CW-1:0] dummy_in;
   logic [CW-1:0] n_in;
   logic [JW-1:0] jump;

   assign dummy_in = dummy_ff + CW'(!req_data.is_real);
   assign n_in     = CW'(load_idx_ff) + CW'(1);
   assign jump     = JW'(1) << lvl_ff;

   // a full buffer closes the vector as well
   assign stat.vec_end     = req_data.last_element ||
                             (load_idx_ff == IW'(MAX_ELEMENTS - 1));
   assign stat.more_levels = jump < {1'b0, n_ff};
   assign stat.emit_last   = (CW'(emit_idx_ff) + CW'(1)) == n_ff;

   // shifter network: each slot pulls from slot j + 2^k at level k
   genvar gj, gl;
   generate
      for (gj = 0; gj < MAX_ELEMENTS; gj++) begin : g_slot
         logic [LEVELS-1:0]           hit;
         logic [opc_pkg::VALUE_W-1:0] lv [LEVELS];
         logic [CW-1:0]               ls [LEVELS];

         for (gl = 0; gl < LEVELS; gl++) begin : g_lvl
            if (gj + 2**gl < MAX_ELEMENTS) begin : g_src
               assign hit[gl] = (lvl_ff == LW'(gl)) &&
                                (CW'(gj + 2**gl) < n_ff) &&
                                step_ff[gj + 2**gl][gl];
               assign lv[gl]  = val_ff[gj + 2**gl];
               assign ls[gl]  = step_ff[gj + 2**gl];
            end else begin : g_nosrc
               assign hit[gl] = 1'b0;
               assign lv[gl]  = '0;
               assign ls[gl]  = '0;
            end
         end

         always_comb begin
            val_in[gj]  = val_ff[gj];
            step_in[gj] = step_ff[gj];
            for (int l = 0; l < LEVELS; l++) begin
               if (hit[l]) begin
                  val_in[gj]  = lv[l];
                  step_in[gj] = ls[l];
               end
            end
         end
      end
   endgenerate

   // slot storage: load writes one slot, a level updates all, emit shifts down
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff[load_idx_ff]  <= req_data.value;
         step_ff[load_idx_ff] <= req_data.is_real ? dummy_in : '0;
      end else if (cmd.level) begin
         for (int j = 0; j < MAX_ELEMENTS; j++) begin
            val_ff[j]  <= val_in[j];
            step_ff[j] <= step_in[j];
         end
      end else if (cmd.emit) begin
         for (int j = 0; j < MAX_ELEMENTS - 1; j++) begin
            val_ff[j] <= val_ff[j + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff <= '0;
         dummy_ff    <= '0;
         n_ff        <= '0;
         nreal_ff    <= '0;
         lvl_ff      <= '0;
         emit_idx_ff <= '0;
      end else begin
         if (cmd.load) begin
            if (stat.vec_end) begin
               load_idx_ff <= '0;
               dummy_ff    <= '0;
               n_ff        <= n_in;
               nreal_ff    <= n_in - dummy_in;
               lvl_ff      <= '0;
               emit_idx_ff <= '0;
            end else begin
               load_idx_ff <= load_idx_ff + IW'(1);
               dummy_ff    <= dummy_in;
            end
         end
         if (cmd.level) begin
            lvl_ff <= lvl_ff + LW'(1);
         end
         if (cmd.emit) begin
            emit_idx_ff <= emit_idx_ff + IW'(1);
         end
      end
   end

   assign rsp_data.out_value   = val_ff[0];
   assign rsp_data.out_real    = CW'(emit_idx_ff) < nreal_ff;
   assign rsp_data.real_count  = opc_pkg::COUNT_W'(nreal_ff);
   assign rsp_data.last_result = stat.emit_last;

endmodule

@@ src/order_preserving_compaction.sv @@
// ----------------------------------------------------------------------------
// order_preserving_compaction
// Squeezes dummy elements out of a vector while keeping the real ones in order.
// ----------------------------------------------------------------------------
// Usage:
//   Elements arrive on the req_ channel, one transfer per element, with a flag
//   marking real elements and one marking the last element of the vector. A
//   vector also closes when it fills all MAX_ELEMENTS slots.
//   After the closing element, the block runs ceil(log2(n)) shifter levels
//   and hands over to output. It then returns n
//   results on the rsp_ channel, one transfer per slot, real elements first in
//   their original order, with the real count and a mark on the final slot.
// Sequencing:
//   A vector of n elements is loaded one element per transfer, passed through
//   the shifter levels as the shifter level counter steps them, then returned;
//   the output shift moves one slot per cycle unless rsp_stall holds it.
//   req_stall is high from the closing element until the final result
//   transfer; one vector is in flight at a time.
// Reset: clears the sequencer and counters; slot contents need no clearing.
// Stall: a stalled result holds steady, the slot array shifts only on transfer.
// ----------------------------------------------------------------------------
module order_preserving_compaction #(
   parameter int MAX_ELEMENTS = opc_pkg::DEF_MAX_ELEMENTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  opc_pkg::opc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output opc_pkg::opc_rsp_type rsp_data
);

   // command and status between sequencer and datapath
   opc_pkg::opc_cmd_type  cmd;
   opc_pkg::opc_stat_type stat;

   opc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slots, prefix dummy count, shifter network and output shift
   opc_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule
